// File: src/nonuniform_derivative_stream_defines.svh
// Assertion macros used by the derivative stream checker.
`ifndef NONUNIFORM_DERIVATIVE_STREAM_DEFINES_SVH
`define NONUNIFORM_DERIVATIVE_STREAM_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define NDS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define NDS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/nds_pkg.sv
// Shared types for the derivative stream controller and datapath.
package nds_pkg;

  // Which stored sample forms the left end of the difference.
  typedef enum logic {
    PAIR_NEWER = 1'b0,
    PAIR_OLDER = 1'b1
  } pair_sel_t;

  // Commands from controller to datapath.
  typedef struct packed {
    logic      cap_in;     // latch the accepted item
    logic      diff_go;    // register dx and dy
    pair_sel_t pair_sel;   // left sample of the difference
    logic      div_start;  // start the serial divider
    logic      push;       // shift history: older <= newer <= current
    logic      out_load;   // load a formatted quotient into the output register
    logic      out_lone;   // load the lone-sample result
    logic      out_end;    // end_of_series flag for out_load
  } nds_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic cur_last;   // latched item closes its series
    logic div_done;   // quotient ready
    logic out_full;   // output register still holds an item
  } nds_sts_t;

endpackage

// File: src/nds_div.sv
// Restoring bit-serial divider with a sticky quotient overflow flag.
module nds_div import nds_pkg::*; #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int FRAC_BITS    = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic [SAMPLE_WIDTH:0]   num,
  input  logic [SAMPLE_WIDTH:0]   den,
  output logic                    done,
  output logic [SAMPLE_WIDTH-1:0] quot,
  output logic                    ovf
);

  localparam int NB    = SAMPLE_WIDTH + 1 + FRAC_BITS;
  localparam int CNT_W = $clog2(NB);

  logic [NB-1:0]           num_r, num_nxt;
  logic [SAMPLE_WIDTH:0]   den_r, den_nxt;
  logic [SAMPLE_WIDTH:0]   rem_r, rem_nxt;
  logic [SAMPLE_WIDTH-1:0] quot_r, quot_nxt;
  logic                    ovf_r, ovf_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic                    busy_r, busy_nxt;
  logic                    done_r, done_nxt;

  logic [SAMPLE_WIDTH+1:0] rem_sh;
  logic [SAMPLE_WIDTH+1:0] rem_sub;
  logic                    take;

  // one quotient bit per cycle
  always_comb begin
    rem_sh  = {rem_r, num_r[NB-1]};
    take    = rem_sh >= {1'b0, den_r};
    rem_sub = rem_sh - {1'b0, den_r};

    num_nxt  = num_r;
    den_nxt  = den_r;
    rem_nxt  = rem_r;
    quot_nxt = quot_r;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;

    if (start) begin
      num_nxt  = NB'(num) << FRAC_BITS;
      den_nxt  = den;
      rem_nxt  = '0;
      quot_nxt = '0;
      ovf_nxt  = 1'b0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt  = num_r << 1;
      rem_nxt  = take ? rem_sub[SAMPLE_WIDTH:0] : rem_sh[SAMPLE_WIDTH:0];
      // bits pushed past the top only matter as "too large"
      ovf_nxt  = ovf_r | quot_r[SAMPLE_WIDTH-1];
      quot_nxt = {quot_r[SAMPLE_WIDTH-2:0], take};
      cnt_nxt  = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(NB - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    rem_r  <= rem_nxt;
    quot_r <= quot_nxt;
    ovf_r  <= ovf_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;
  assign ovf  = ovf_r;

endmodule

// File: src/nds_dpath.sv
// Datapath: sample history, differences, divider and output register.
module nds_dpath import nds_pkg::*; #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int FRAC_BITS    = 16
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [SAMPLE_WIDTH-1:0] in_x,
  input  logic [SAMPLE_WIDTH-1:0] in_y,
  input  logic                    in_last,
  input  nds_cmd_t                cmd,
  output nds_sts_t                sts,
  input  logic                    out_ready,
  output logic                    out_valid,
  output logic [SAMPLE_WIDTH-1:0] out_slope,
  output logic                    out_zero,
  output logic                    out_clip,
  output logic                    out_end
);

  localparam int W = SAMPLE_WIDTH;
  localparam logic [W-1:0] POS_MAX = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] NEG_MIN = {1'b1, {(W-1){1'b0}}};

  logic [W-1:0] cur_x_r, cur_y_r, newer_x_r, newer_y_r, older_x_r, older_y_r;
  logic         cur_last_r;
  logic [W:0]   dx_r, dy_r;

  logic [W-1:0] base_x, base_y;
  logic [W:0]   dx_nxt, dy_nxt;
  logic [W:0]   dx_mag, dy_mag;

  logic         div_done;
  logic [W-1:0] quot;
  logic         ovf;

  logic [W-1:0] fmt_slope;
  logic         fmt_zero, fmt_clip;

  logic         out_valid_r, out_valid_nxt;
  logic [W-1:0] slope_r;
  logic         zero_r, clip_r, end_r;

  // sample history
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      cur_x_r    <= in_x;
      cur_y_r    <= in_y;
      cur_last_r <= in_last;
    end
    if (cmd.push) begin
      older_x_r <= newer_x_r;
      older_y_r <= newer_y_r;
      newer_x_r <= cur_x_r;
      newer_y_r <= cur_y_r;
    end
  end

  // exact differences, one bit wider than a sample
  always_comb begin
    base_x = (cmd.pair_sel == PAIR_OLDER) ? older_x_r : newer_x_r;
    base_y = (cmd.pair_sel == PAIR_OLDER) ? older_y_r : newer_y_r;
    dx_nxt = {cur_x_r[W-1], cur_x_r} - {base_x[W-1], base_x};
    dy_nxt = {cur_y_r[W-1], cur_y_r} - {base_y[W-1], base_y};
  end

  always_ff @(posedge clk) begin
    if (cmd.diff_go) begin
      dx_r <= dx_nxt;
      dy_r <= dy_nxt;
    end
  end

  assign dx_mag = dx_r[W] ? (~dx_r + 1'b1) : dx_r;
  assign dy_mag = dy_r[W] ? (~dy_r + 1'b1) : dy_r;

  nds_div #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (dy_mag),
    .den   (dx_mag),
    .done  (div_done),
    .quot  (quot),
    .ovf   (ovf)
  );

  // sign, saturation and zero-spacing handling
  always_comb begin
    fmt_zero  = 1'b0;
    fmt_clip  = 1'b0;
    fmt_slope = quot;
    if (dx_r == '0) begin
      fmt_zero = 1'b1;
      if (dy_r == '0) begin
        fmt_slope = '0;
      end else if (dy_r[W]) begin
        fmt_slope = NEG_MIN;
      end else begin
        fmt_slope = POS_MAX;
      end
    end else if (dx_r[W] ^ dy_r[W]) begin
      if (ovf || (quot > NEG_MIN)) begin
        fmt_clip  = 1'b1;
        fmt_slope = NEG_MIN;
      end else begin
        fmt_slope = ~quot + 1'b1;
      end
    end else if (ovf || quot[W-1]) begin
      fmt_clip  = 1'b1;
      fmt_slope = POS_MAX;
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.out_load || cmd.out_lone) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_lone) begin
      slope_r <= '0;
      zero_r  <= 1'b0;
      clip_r  <= 1'b0;
      end_r   <= 1'b1;
    end else if (cmd.out_load) begin
      slope_r <= fmt_slope;
      zero_r  <= fmt_zero;
      clip_r  <= fmt_clip;
      end_r   <= cmd.out_end;
    end
  end

  assign sts.cur_last = cur_last_r;
  assign sts.div_done = div_done;
  assign sts.out_full = out_valid_r;

  assign out_valid = out_valid_r;
  assign out_slope = slope_r;
  assign out_zero  = zero_r;
  assign out_clip  = clip_r;
  assign out_end   = end_r;

endmodule

// File: src/nds_ctrl.sv
// Controller: series position tracking and sequencing of divisions.
module nds_ctrl import nds_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  nds_sts_t sts,
  output nds_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECIDE = 6'b000010,
    S_LONE   = 6'b000100,
    S_START  = 6'b001000,
    S_DIV    = 6'b010000,
    S_EMIT   = 6'b100000
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] held_r, held_nxt;
  logic       end_r, end_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    held_nxt  = held_r;
    end_nxt   = end_r;
    cmd       = '0;
    cmd.pair_sel = PAIR_NEWER;
    cmd.out_end  = end_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.cap_in = 1'b1;
          state_nxt  = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (held_r == 2'd0) begin
          if (sts.cur_last) begin
            state_nxt = S_LONE;
          end else begin
            cmd.push  = 1'b1;
            held_nxt  = 2'd1;
            state_nxt = S_IDLE;
          end
        end else begin
          // first point of a series uses its forward neighbor only
          cmd.diff_go  = 1'b1;
          cmd.pair_sel = (held_r == 2'd1) ? PAIR_NEWER : PAIR_OLDER;
          end_nxt      = 1'b0;
          state_nxt    = S_START;
        end
      end
      S_LONE: begin
        if (!sts.out_full) begin
          cmd.out_lone = 1'b1;
          held_nxt     = 2'd0;
          state_nxt    = S_IDLE;
        end
      end
      S_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (sts.div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!sts.out_full) begin
          cmd.out_load = 1'b1;
          if (end_r) begin
            held_nxt  = 2'd0;
            state_nxt = S_IDLE;
          end else if (sts.cur_last) begin
            // backward difference for the closing point
            cmd.diff_go  = 1'b1;
            cmd.pair_sel = PAIR_NEWER;
            end_nxt      = 1'b1;
            state_nxt    = S_START;
          end else begin
            cmd.push  = 1'b1;
            held_nxt  = 2'd2;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      held_r  <= 2'd0;
      end_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      held_r  <= held_nxt;
      end_r   <= end_nxt;
    end
  end

endmodule

// File: src/nonuniform_derivative_stream.sv
// Numerical derivative of a stream of fixed-point (x, y) samples, one item at a time.
// Each sample is fully handled, and any result loaded, before the next sample is accepted.
// A closing sample that follows others runs two divisions, the second for its own backward
// difference. A first sample only enters the history; a lone sample gets a zero result without
// a division. A full output register stalls every load of a result.
// Reset (rst_n low, synchronous) empties the sample history and the output register.
module nonuniform_derivative_stream import nds_pkg::*; #(
  parameter int SAMPLE_WIDTH = 32,
  parameter int FRAC_BITS    = 16,
  localparam int IN_DATA_W   = ((2 * SAMPLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_DATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // x_value, y_value
  input  logic                  in_tlast,   // last_sample
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // slope
  output logic [1:0]            out_tuser,  // zero_spacing, clipped
  output logic                  out_tlast   // end_of_series
);

  nds_cmd_t                cmd;
  nds_sts_t                sts;
  logic [SAMPLE_WIDTH-1:0] slope;
  logic                    zero_flag, clip_flag;

  nds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  nds_dpath #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .FRAC_BITS    (FRAC_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_x      (in_tdata[SAMPLE_WIDTH-1:0]),
    .in_y      (in_tdata[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH]),
    .in_last   (in_tlast),
    .cmd       (cmd),
    .sts       (sts),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_slope (slope),
    .out_zero  (zero_flag),
    .out_clip  (clip_flag),
    .out_end   (out_tlast)
  );

  assign out_tdata = OUT_DATA_W'(slope);
  assign out_tuser = {clip_flag, zero_flag};

endmodule

// File: src/nds_checker.sv
// Port-level checks for the derivative stream, bound to the top level.
`include "nonuniform_derivative_stream_defines.svh"

module nds_checker #(
  parameter int SAMPLE_WIDTH = 32,
  localparam int OUT_DATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [1:0]            out_tuser,
  input logic                  out_tlast
);

  localparam logic [SAMPLE_WIDTH-1:0] POS_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
  localparam logic [SAMPLE_WIDTH-1:0] NEG_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

  logic [SAMPLE_WIDTH-1:0] slope;
  logic [OUT_DATA_W+2:0]   out_bus;
  logic                    out_stall;
  logic                    zero_item, clip_item;
  logic                    slope_at_limit;

  assign slope          = out_tdata[SAMPLE_WIDTH-1:0];
  assign out_bus        = {out_tlast, out_tuser, out_tdata};
  assign out_stall      = out_tvalid && !out_tready;
  assign zero_item      = out_tvalid && out_tuser[0];
  assign clip_item      = out_tvalid && out_tuser[1];
  assign slope_at_limit = (slope == POS_MAX) || (slope == NEG_MIN);

  // a stalled result holds
  `NDS_ASSERT_NEXT(a_out_hold, out_stall, out_tvalid && $stable(out_bus), "stalled result changed")

  // zero spacing never reports a clip
  `NDS_ASSERT_NOW(a_flags_exclusive, zero_item, !out_tuser[1], "zero spacing with clip")

  // zero spacing gives zero or a full-scale slope
  `NDS_ASSERT_NOW(a_zero_sat, zero_item, slope == '0 || slope_at_limit, "bad zero-spacing slope")

  // a clipped quotient sits at a range limit
  `NDS_ASSERT_NOW(a_clip_sat, clip_item, slope_at_limit, "clipped slope not at a limit")

endmodule

bind nonuniform_derivative_stream nds_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_nds_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
